@@ design/lcag_pkg.sv @@
// ----------------------------------------------------------------------------
// lcag_pkg
// Shared types, constants and the sine table for the LED colour sequencer.
// ----------------------------------------------------------------------------
package lcag_pkg;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_BRIGHT = 2'd0;
    localparam logic [1:0] REG_DEBUG  = 2'd1;
    localparam logic [1:0] REG_FPM    = 2'd2;

    // Animation codes
    localparam logic [2:0] MODE_RAINBOW = 3'd0;
    localparam logic [2:0] MODE_BLUE    = 3'd1;
    localparam logic [2:0] MODE_PURPLE  = 3'd2;
    localparam logic [2:0] MODE_FIRE    = 3'd3;
    localparam logic [2:0] MODE_OCEAN   = 3'd4;
    localparam logic [2:0] MODE_CANDY   = 3'd5;

    localparam int NUM_ANIM     = 6;
    localparam int JOBQ_DEPTH   = 2;
    localparam int SINE_ENTRIES = 256;
    localparam int SINE_IW      = $clog2(SINE_ENTRIES);
    localparam int PHASE_W      = 16;

    // Phase increments per frame for each rate, fraction of a turn
    function automatic logic [PHASE_W-1:0] rate_inc(input int hundredths);
        longint num;
        num = (longint'(hundredths) * 113) <<< PHASE_W;
        return PHASE_W'((num + 35500) / 71000);
    endfunction

    // Quarter-wave polynomial, Q1.15
    function automatic logic [15:0] quarter_wave(input longint x);
        longint x2, i, o, v;
        x2 = (x * x) >>> 15;
        i  = 21024 - ((2320 * x2) >>> 15);
        o  = 51472 - ((x2 * i) >>> 15);
        v  = (x * o) >>> 15;
        if (v > 32767) v = 32767;
        return 16'(v);
    endfunction

    // Full sine table entry, used only to build the table
    function automatic logic signed [15:0] sine_entry(input logic [SINE_IW-1:0] k);
        longint q, r, x;
        logic [15:0] v;
        q = (4 * longint'(k)) / SINE_ENTRIES;
        r = 4 * longint'(k) - q * SINE_ENTRIES;
        x = (r * 32768) / SINE_ENTRIES;
        if (q % 2 == 1) x = 32768 - x;
        v = quarter_wave(x);
        return (q >= 2) ? -$signed(v) : $signed(v);
    endfunction

    // Whole table packed into one constant, entry k in bits 16k+15..16k
    function automatic logic [SINE_ENTRIES*16-1:0] build_sine_rom();
        logic [SINE_ENTRIES*16-1:0] rom;
        rom = '0;
        for (int k = 0; k < SINE_ENTRIES; k++)
            rom[k*16 +: 16] = sine_entry(SINE_IW'(k));
        return rom;
    endfunction

    localparam logic [SINE_ENTRIES*16-1:0] SINE_ROM = build_sine_rom();

    // Constant table lookup
    function automatic logic signed [15:0] sine_lookup(input logic [SINE_IW-1:0] k);
        return $signed(SINE_ROM[{k, 4'b0000} +: 16]);
    endfunction

    // Job handed from the front part to the back part
    typedef struct packed {
        logic        dbg;
        logic [2:0]  mode;
        logic [31:0] frame;
        logic [7:0]  bright;
    } job_t;

endpackage

@@ design/lcag_front.sv @@
// ----------------------------------------------------------------------------
// lcag_front
// Accepts ticks, holds configuration and counters, queues render jobs.
// ----------------------------------------------------------------------------
module lcag_front
    import lcag_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_idx,
    input  logic [31:0] cfg_data,
    output logic [31:0] cfg_rdata,
    input  logic [1:0]  cfg_ridx,
    output logic        job_valid,
    input  logic        job_ready,
    output job_t        job
);
    logic [7:0]  bright_reg;
    logic        dbg_reg;
    logic [15:0] fpm_reg;
    logic [31:0] frame_reg, frame_next;
    logic [15:0] mcnt_reg, mcnt_next;
    logic [2:0]  anim_reg, anim_next;
    logic [15:0] mcnt_inc;
    logic        adv;
    logic        take, pop;
    job_t        job_in;
    job_t        q_reg [JOBQ_DEPTH];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  cnt_reg;

    // Job queue handshake
    assign s_tready  = (cnt_reg != 2'(JOBQ_DEPTH));
    assign take      = s_tvalid && s_tready && s_tdata[0];
    assign job_valid = (cnt_reg != 2'd0);
    assign job       = q_reg[rd_ptr_reg];
    assign pop       = job_valid && job_ready;

    assign mcnt_inc  = mcnt_reg + 16'd1;
    assign adv       = mcnt_inc >= fpm_reg;

    // Job built from post-update counters
    always_comb begin
        job_in.dbg    = dbg_reg;
        job_in.bright = bright_reg;
        job_in.frame  = dbg_reg ? frame_reg : frame_reg + 32'd1;
        job_in.mode   = anim_reg;
        if (!dbg_reg && adv)
            job_in.mode = (anim_reg == 3'(NUM_ANIM - 1)) ? MODE_RAINBOW : anim_reg + 3'd1;
    end

    // Counter next state; a debug write of 1 clears the frame counters
    always_comb begin
        frame_next = frame_reg;
        mcnt_next  = mcnt_reg;
        anim_next  = anim_reg;
        if (take && !dbg_reg) begin
            frame_next = job_in.frame;
            mcnt_next  = adv ? 16'd0 : mcnt_inc;
            anim_next  = job_in.mode;
        end
        if (cfg_we && cfg_idx == REG_DEBUG && cfg_data[0]) begin
            frame_next = '0;
            mcnt_next  = '0;
        end
    end

    always_comb begin
        case (cfg_ridx)
            REG_BRIGHT: cfg_rdata = {24'd0, bright_reg};
            REG_DEBUG:  cfg_rdata = {31'd0, dbg_reg};
            REG_FPM:    cfg_rdata = {16'd0, fpm_reg};
            default:    cfg_rdata = 32'd0;
        endcase
    end

    // Configuration, counter and queue pointer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bright_reg <= 8'd128;
            dbg_reg    <= 1'b0;
            fpm_reg    <= 16'd600;
            frame_reg  <= '0;
            mcnt_reg   <= '0;
            anim_reg   <= MODE_RAINBOW;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            frame_reg <= frame_next;
            mcnt_reg  <= mcnt_next;
            anim_reg  <= anim_next;
            if (take) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, take} - {1'b0, pop};
            if (cfg_we) begin
                case (cfg_idx)
                    REG_BRIGHT: bright_reg <= cfg_data[7:0];
                    REG_DEBUG:  dbg_reg    <= cfg_data[0];
                    REG_FPM:    fpm_reg    <= cfg_data[15:0];
                    default:    ;
                endcase
            end
        end
    end

    // Queue storage
    always_ff @(posedge aclk) begin
        if (take) q_reg[wr_ptr_reg] <= job_in;
    end
endmodule

@@ design/lcag_back.sv @@
// ----------------------------------------------------------------------------
// lcag_back
// Renders one job: phase, sine lookups, colour choice, brightness scale.
// ----------------------------------------------------------------------------
module lcag_back
    import lcag_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        job_valid,
    output logic        job_ready,
    input  job_t        job,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata
);
    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_PHASE = 8'b00000010,
        S_WAVE  = 8'b00000100,
        S_PROD  = 8'b00001000,
        S_TERM  = 8'b00010000,
        S_COL   = 8'b00100000,
        S_SCALE = 8'b01000000,
        S_OUT   = 8'b10000000
    } st_t;

    localparam logic [PHASE_W-1:0] QTR = PHASE_W'(1 << (PHASE_W - 2));

    st_t         st_reg;
    job_t        j_reg;
    logic [PHASE_W-1:0] p1_reg, p2_reg;
    logic signed [15:0] s1_reg, s2_reg;
    logic [15:0] pq_reg;
    logic signed [31:0] prod_reg;
    logic [2:0]  region_reg;
    logic [7:0]  rem_reg;
    logic [15:0] fq_reg;
    logic [6:0]  w_reg;
    logic [7:0]  qv_reg, tv_reg;
    logic [7:0]  r_reg, g_reg, b_reg;
    logic [55:0] out_reg;
    logic [PHASE_W-1:0] inc1, inc2;
    logic [7:0]  h, base;
    logic [2:0]  region;
    logic [7:0]  rem;
    logic [31:0] mag;
    logic [15:0] term;
    logic [7:0]  qv, tv;
    logic [7:0]  rc, gc, bc;
    logic [7:0]  ro, go, bo;

    // Exact x/255 for x up to 255*255
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [15:0] t;
        t = x + {8'd0, x[15:8]} + 16'd1;
        return t[15:8];
    endfunction

    assign job_ready = (st_reg == S_IDLE);
    assign m_tvalid  = (st_reg == S_OUT);
    assign m_tdata   = out_reg;

    // Rate selection per mode
    always_comb begin
        case (j_reg.mode)
            MODE_BLUE:   inc1 = rate_inc(5);
            MODE_PURPLE: inc1 = rate_inc(4);
            MODE_FIRE:   inc1 = rate_inc(30);
            MODE_OCEAN:  inc1 = rate_inc(6);
            default:     inc1 = rate_inc(3);
        endcase
        inc2 = rate_inc(17);
    end

    // Rainbow hue region by thresholds
    always_comb begin
        h = {j_reg.frame[6:0], 1'b0};
        if (h >= 8'd215) begin
            region = 3'd5; base = 8'd215;
        end else if (h >= 8'd172) begin
            region = 3'd4; base = 8'd172;
        end else if (h >= 8'd129) begin
            region = 3'd3; base = 8'd129;
        end else if (h >= 8'd86) begin
            region = 3'd2; base = 8'd86;
        end else if (h >= 8'd43) begin
            region = 3'd1; base = 8'd43;
        end else begin
            region = 3'd0; base = 8'd0;
        end
        rem = 8'((h - base) * 8'd6);
    end

    // Fire term and rainbow ramps
    always_comb begin
        mag  = prod_reg[31] ? 32'(-prod_reg) : 32'(prod_reg);
        term = 16'((46'(mag[29:0]) * 46'd19661) >> 30);
        qv   = 8'((16'd255 * (16'd255 - ((16'd255 * 16'(rem_reg)) >> 8))) >> 8);
        tv   = 8'((16'd255 * (16'd255 - ((16'd255 * 16'(8'd255 - rem_reg)) >> 8))) >> 8);
    end

    // Colour choice
    always_comb begin
        rc = 8'd0; gc = 8'd0; bc = 8'd0;
        if (j_reg.dbg) begin
            rc = 8'd255; gc = 8'd127;
        end else begin
            case (j_reg.mode)
                MODE_BLUE: begin
                    gc = 8'((24'(pq_reg) * 24'd128) >> 16);
                    bc = 8'((24'(pq_reg) * 24'd255) >> 16);
                end
                MODE_PURPLE: begin
                    rc = 8'((24'(pq_reg) * 24'd200) >> 16);
                    bc = 8'((24'(pq_reg) * 24'd255) >> 16);
                end
                MODE_FIRE: begin
                    rc = 8'((24'(fq_reg) * 24'd255) >> 16);
                    gc = 8'((24'(fq_reg) * 24'd100) >> 16);
                end
                MODE_OCEAN: begin
                    gc = 8'((24'(pq_reg) * 24'd180) >> 16);
                    bc = 8'((24'(pq_reg) * 24'd255) >> 16);
                end
                MODE_CANDY: begin
                    // white*27/100 by reciprocal, white below 100
                    rc = 8'd255;
                    gc = {1'b0, w_reg};
                    bc = 8'd200 + 8'((24'(w_reg) * 24'd141561) >> 19);
                end
                default: begin
                    case (region_reg)
                        3'd0:    begin rc = 8'd255; gc = tv_reg; end
                        3'd1:    begin rc = qv_reg; gc = 8'd255; end
                        3'd2:    begin gc = 8'd255; bc = tv_reg; end
                        3'd3:    begin gc = qv_reg; bc = 8'd255; end
                        3'd4:    begin rc = tv_reg; bc = 8'd255; end
                        default: begin rc = 8'd255; bc = qv_reg; end
                    endcase
                end
            endcase
        end
    end

    // Brightness scale
    always_comb begin
        ro = div255(16'(r_reg) * 16'(j_reg.bright));
        go = div255(16'(g_reg) * 16'(j_reg.bright));
        bo = div255(16'(b_reg) * 16'(j_reg.bright));
    end

    // Render sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_IDLE;
        end else begin
            unique case (st_reg)
                S_IDLE: if (job_valid) begin
                    j_reg  <= job;
                    st_reg <= S_PHASE;
                end
                S_PHASE: begin
                    p1_reg <= PHASE_W'(j_reg.frame[PHASE_W-1:0] * inc1);
                    p2_reg <= PHASE_W'(j_reg.frame[PHASE_W-1:0] * inc2) + QTR;
                    st_reg <= S_WAVE;
                end
                S_WAVE: begin
                    s1_reg <= sine_lookup(p1_reg[PHASE_W-1 -: SINE_IW]);
                    s2_reg <= sine_lookup(p2_reg[PHASE_W-1 -: SINE_IW]);
                    st_reg <= S_PROD;
                end
                S_PROD: begin
                    // 32768 + s, s never below -32767
                    pq_reg     <= {~s1_reg[15], s1_reg[14:0]};
                    prod_reg   <= s1_reg * s2_reg;
                    region_reg <= region;
                    rem_reg    <= rem;
                    st_reg     <= S_TERM;
                end
                S_TERM: begin
                    fq_reg <= prod_reg[31] ? 16'd45875 - term : 16'd45875 + term;
                    w_reg  <= 7'((24'(pq_reg) * 24'd100) >> 16);
                    qv_reg <= qv;
                    tv_reg <= tv;
                    st_reg <= S_COL;
                end
                S_COL: begin
                    r_reg <= rc; g_reg <= gc; b_reg <= bc;
                    st_reg <= S_SCALE;
                end
                S_SCALE: begin
                    out_reg <= {5'd0, j_reg.mode, go, ro, bo, bo, go, ro};
                    st_reg  <= S_OUT;
                end
                S_OUT: if (m_tready) st_reg <= S_IDLE;
                default: st_reg <= S_IDLE;
            endcase
        end
    end
endmodule

@@ design/led_color_animation_generator_top.sv @@
// ----------------------------------------------------------------------------
// led_color_animation_generator_top
// One colour result per frame tick, six cycling animations.
// ----------------------------------------------------------------------------
// Each frame tick of 1 on the input stream yields one colour result. The front
// takes ticks into a two-entry job queue; the renderer works on one job at a
// time and takes it through load, phase, sine lookup, product, fire term,
// colour, brightness scale and output before it loads the next, and it stays
// in output while m_tready is low. Ticks of 0 are taken whenever the queue has
// room and give nothing.
module led_color_animation_generator_top
    import lcag_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] frame_tick
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // red, green, blue, pixel_word, mode_shown
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic job_valid, job_ready;
    job_t job;

    assign pready = 1'b1;

    lcag_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .cfg_we(psel && penable && pwrite), .cfg_idx(paddr[3:2]),
        .cfg_data(pwdata), .cfg_rdata(prdata), .cfg_ridx(paddr[3:2]),
        .job_valid(job_valid), .job_ready(job_ready), .job(job)
    );

    lcag_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .job_valid(job_valid), .job_ready(job_ready), .job(job),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // Result must hold while stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed while stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[50:48] <= MODE_CANDY) else $error("bad mode");
    assert property (@(posedge aclk) pready) else $error("pready low");
endmodule

@@ bench/tb_checker.sv @@
// ----------------------------------------------------------------------------
// tb_checker
// Predicts and checks the colour results of the LED animation sequencer.
// ----------------------------------------------------------------------------
// Watches the input stream, the result stream and the register port. Every
// accepted tick of 1 updates a local copy of the frame counters unless debug
// is set, and predicts the scaled colour; results are compared in order.
module tb_checker
    import lcag_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] frame_tick
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,   // red, green, blue, pixel_word, mode_shown
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending,
    output int          colours_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [2:0]  mode;
        logic [23:0] word;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
    } colour_t;

    colour_t     colour_q[$];
    logic [31:0] frames;
    logic [15:0] mode_frames;
    logic [2:0]  anim;
    logic [7:0]  bright;
    logic        dbg;
    logic [15:0] fpm;

    // Sine value at a rate (hundredths of rad per frame) plus a phase offset
    function automatic longint wave_at(input int hundredths, input longint offset);
        longint inc, ph, k, q, r, x, x2, i, o, v;
        inc = ((longint'(hundredths) * 113 * 65536) + 35500) / 71000;
        ph  = (longint'(frames) * inc + offset) & 65535;
        k   = ph >> 8;
        q   = (4 * k) / 256;
        r   = 4 * k - q * 256;
        x   = (r * 32768) / 256;
        if (q[0]) x = 32768 - x;
        x2 = (x * x) >> 15;
        i  = 21024 - ((2320 * x2) >> 15);
        o  = 51472 - ((x2 * i) >> 15);
        v  = (x * o) >> 15;
        if (v > 32767) v = 32767;
        return (q >= 2) ? -v : v;
    endfunction

    function automatic colour_t frame_colour();
        longint r, g, b, p, h, region, rem, q, t, s, c, prod, mag, f, w;
        colour_t res;
        if (dbg) begin
            r = 255; g = 127; b = 0;
        end else begin
            case (anim)
                MODE_BLUE: begin
                    p = 32768 + wave_at(5, 0); r = 0; g = (p * 128) >> 16; b = (p * 255) >> 16;
                end
                MODE_PURPLE: begin
                    p = 32768 + wave_at(4, 0); r = (p * 200) >> 16; g = 0; b = (p * 255) >> 16;
                end
                MODE_FIRE: begin
                    s = wave_at(30, 0);
                    c = wave_at(17, 16384);
                    prod = s * c;
                    mag = (prod < 0) ? -prod : prod;
                    f = (prod < 0) ? 45875 - ((mag * 19661) >> 30)
                                   : 45875 + ((mag * 19661) >> 30);
                    r = (f * 255) >> 16; g = (f * 100) >> 16; b = 0;
                end
                MODE_OCEAN: begin
                    p = 32768 + wave_at(6, 0); r = 0; g = (p * 180) >> 16; b = (p * 255) >> 16;
                end
                MODE_CANDY: begin
                    p = 32768 + wave_at(3, 0); w = (p * 100) >> 16;
                    r = 255; g = w; b = 200 + (w * 27) / 100;
                end
                default: begin
                    h = (longint'(frames) << 1) & 255;
                    region = h / 43;
                    rem = ((h - region * 43) * 6) & 255;
                    q = (255 * (255 - ((255 * rem) >> 8))) >> 8;
                    t = (255 * (255 - ((255 * (255 - rem)) >> 8))) >> 8;
                    case (region)
                        0: begin r = 255; g = t; b = 0; end
                        1: begin r = q; g = 255; b = 0; end
                        2: begin r = 0; g = 255; b = t; end
                        3: begin r = 0; g = q; b = 255; end
                        4: begin r = t; g = 0; b = 255; end
                        default: begin r = 255; g = 0; b = q; end
                    endcase
                end
            endcase
        end
        res.red   = 8'(((r & 255) * bright) / 255);
        res.green = 8'(((g & 255) * bright) / 255);
        res.blue  = 8'(((b & 255) * bright) / 255);
        res.word  = {res.green, res.red, res.blue};
        res.mode  = anim;
        return res;
    endfunction

    always @(posedge aclk) begin
        colour_t exp_c, got;
        if (!aresetn) begin
            frames = '0; mode_frames = '0; anim = MODE_RAINBOW;
            bright = 8'd128; dbg = 1'b0; fpm = 16'd600;
            colour_q.delete();
            fail_count <= 0; colours_seen <= 0;
        end else begin
            // register writes
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_BRIGHT: bright = pwdata[7:0];
                    REG_DEBUG: begin
                        dbg = pwdata[0];
                        if (pwdata[0]) begin
                            frames = '0; mode_frames = '0;
                        end
                    end
                    REG_FPM: fpm = pwdata[15:0];
                    default: ;
                endcase
            end
            // tick transaction: advance counters unless in debug, predict colour
            if (s_tvalid && s_tready && s_tdata[0]) begin
                if (!dbg) begin
                    frames = frames + 32'd1;
                    mode_frames = mode_frames + 16'd1;
                    if (mode_frames >= fpm) begin
                        mode_frames = '0;
                        anim = (anim == 3'(NUM_ANIM - 1)) ? MODE_RAINBOW : anim + 3'd1;
                    end
                end
                colour_q.push_back(frame_colour());
            end
            // result transaction
            if (m_tvalid && m_tready) begin
                got = m_tdata[50:0];
                colours_seen <= colours_seen + 1;
                if (colour_q.size() == 0) begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10) $display("unexpected colour %h", got);
                end else begin
                    exp_c = colour_q.pop_front();
                    if (got !== exp_c) begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display({"colour mismatch: exp r%0d g%0d b%0d w%h m%0d, ",
                                      "got r%0d g%0d b%0d w%h m%0d"},
                                exp_c.red, exp_c.green, exp_c.blue, exp_c.word, exp_c.mode,
                                got.red, got.green, got.blue, got.word, got.mode);
                    end
                end
            end
        end
        pending = colour_q.size();
    end
endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the LED colour animation sequencer.
// ----------------------------------------------------------------------------
// Drives frame ticks with random gaps and back-pressure through several
// register settings (brightness, debug, mode length); checking is left to
// tb_checker.
module tb_top
    import lcag_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;   // [0] frame_tick
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;        // red, green, blue, pixel_word, mode_shown
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count, pending, colours_seen;
    bit          calm = 1'b0;
    int          ticks_sent = 0;

    always #6 aclk = ~aclk;

    led_color_animation_generator_top u_top (.*);
    tb_checker u_chk (.*);

    // Result side back-pressure in bursts
    initial begin
        int n;
        forever begin
            @(posedge aclk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 4);
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic send_tick(input logic tick);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1; s_tdata <= {7'($urandom), tick};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        ticks_sent++;
    endtask

    // Let everything drain before touching registers
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic run_phase(input int n, input int zero_pct);
        repeat (n) send_tick($urandom_range(0, 99) >= zero_pct);
        settle();
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // directed: reset values, a null tick, then short modes walk every animation
        send_tick(1'b1); send_tick(1'b0); send_tick(1'b1);
        settle();
        reg_write(REG_FPM, 1);
        reg_write(REG_BRIGHT, 255);
        run_phase(8, 0);
        reg_write(REG_FPM, 0);         // advances on every frame
        reg_write(REG_BRIGHT, 0);
        run_phase(7, 0);
        reg_write(REG_DEBUG, 1);       // steady orange, counters clear
        reg_write(REG_BRIGHT, 255);
        run_phase(4, 0);
        reg_write(REG_DEBUG, 0);
        reg_write(REG_FPM, 32'hFFFF);
        run_phase(3, 0);
        // random phases through various settings
        for (int ph = 0; ph < 12; ph++) begin
            if (ph == 10) calm = 1'b1;
            reg_write(REG_BRIGHT, (ph % 3 == 0) ? 255 : $urandom_range(0, 255));
            reg_write(REG_FPM, (ph % 4 == 0) ? 32'hFFFF : $urandom_range(1, 40));
            reg_write(REG_DEBUG, (ph % 5 == 2) ? 1 : 0);
            if (ph % 5 == 2) reg_write(REG_DEBUG, 0);
            if (ph == 7) reg_write(REG_DEBUG, 1);
            run_phase(52, 15);
        end
        $display("Sent %0d ticks, %0d colours checked across all six animations,", ticks_sent,
                 colours_seen);
        $display("debug orange, brightness extremes and mode lengths 0, 1 and 65535.");
        if (fail_count == 0 && pending == 0) begin
            $display("[led_color_animation_generator_top] OK");
        end else begin
            $display("[led_color_animation_generator_top] ERROR");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("[led_color_animation_generator_top] ERROR");
        $finish;
    end
endmodule
